[rtl/crp_pkg.sv]
`timescale 1ns / 1ps
package crp_pkg;

   localparam int KEY_BITS    = 10;
   localparam int MAX_ENTRIES = 16;
   localparam int SLOT_BITS   = $clog2(MAX_ENTRIES);
   localparam int FILL_BITS   = $clog2(MAX_ENTRIES + 1);
   localparam int KEY_SPACE   = 1 << KEY_BITS;
   localparam int CNT_BITS    = 32;

   typedef logic [KEY_BITS-1:0]  key_type;
   typedef logic [SLOT_BITS-1:0] slot_type;
   typedef logic [FILL_BITS-1:0] fill_type;
   typedef logic [CNT_BITS-1:0]  cnt_type;
   typedef logic [1:0]           policy_type;
   typedef logic [1:0]           kind_type;

   localparam policy_type POLICY_FIFO   = 2'd0;
   localparam policy_type POLICY_LRU    = 2'd1;
   localparam policy_type POLICY_CLOCK  = 2'd2;
   localparam policy_type POLICY_IGNORE = 2'd3;

   localparam kind_type KIND_HIT        = 2'd0;
   localparam kind_type KIND_COMPULSORY = 2'd1;
   localparam kind_type KIND_CAPACITY   = 2'd2;

   localparam logic CSR_POLICY   = 1'b0;
   localparam logic CSR_CAPACITY = 1'b1;

   localparam int CSR_DATA_BITS = 5;

   typedef enum logic [1:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_LOOK,
      ST_UPDATE
   } state_type;

   typedef struct packed {
      logic load;
      logic shift;
      logic set_ref;
      logic clr_ref;
   } cell_op_type;

endpackage

[rtl/cache_replacement_policy.sv]
`timescale 1ns / 1ps
// Cache replacement policy engine: FIFO, LRU and CLOCK over a 16-entry
// fully associative key store held in a row of cells; policy 3 leaves store and counters untouched.
// req_*: one key per transfer (valid/ready). rsp_*: one result per key,
// hit flag, miss class and the four saturating counters after the access.
// csr_*: single-cycle writes, index 0 policy, index 1 capacity (clamped
// to 1..16); write only while no access is in flight.
// Each key passes a look state (seen-map result and key match captured) and an
// update state; on a full-cache CLOCK miss the update first sweeps, clearing one
// set reference bit per step. The next key is taken as the update commits.
// Reset: the 1024-entry seen map is cleared one entry per cycle, and
// req_ready stays low until it is clear; reference bits, fill count,
// pointer and counters clear at once; stored keys are not reset.
// Stall: the result register holds while rsp_ready is low; the next key is
// still taken and looked up, and its update waits for the register.
module cache_replacement_policy (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      req_valid,
   output logic                      req_ready,
   input  crp_pkg::key_type          req_key,
   output logic                      rsp_valid,
   input  logic                      rsp_ready,
   output logic                      rsp_hit,
   output crp_pkg::kind_type         rsp_miss_kind,
   output crp_pkg::cnt_type          rsp_hits_total,
   output crp_pkg::cnt_type          rsp_misses_total,
   output crp_pkg::cnt_type          rsp_compulsory_total,
   output crp_pkg::cnt_type          rsp_capacity_total,
   input  logic                      csr_wr_en,
   input  logic                      csr_index,
   input  logic [crp_pkg::CSR_DATA_BITS-1:0] csr_wdata
);
   import crp_pkg::*;

   localparam cnt_type CNT_MAX = '1;

   state_type   state_ff, state_in;
   policy_type  policy_ff;
   fill_type    capacity_ff, fill_ff, cap_clamped;
   slot_type    ptr_ff, ptr_next;
   key_type     key_ff;
   logic [KEY_BITS-1:0] clr_ff;
   logic        found_ff, seen_ff, byp_ff;
   slot_type    pos_ff;
   logic        found_in;
   slot_type    pos_in;
   cnt_type     hit_cnt_ff, miss_cnt_ff, comp_cnt_ff, capm_cnt_ff;
   logic        rsp_valid_ff, rsp_hit_ff;
   kind_type    rsp_kind_ff;

   key_type     key_vec   [MAX_ENTRIES];
   logic        ref_vec   [MAX_ENTRIES];
   logic        match_vec [MAX_ENTRIES];
   cell_op_type op_vec    [MAX_ENTRIES];

   logic        accept, out_free, active, full, sweep_step, commit, new_ref;
   fill_type    last;
   logic        seen_we, seen_wd, seen_rd;
   logic [KEY_BITS-1:0] seen_wa;

   assign active     = (policy_ff != POLICY_IGNORE);
   assign full       = (fill_ff >= capacity_ff);
   assign last       = fill_ff - 1'b1;
   assign out_free   = !rsp_valid_ff || rsp_ready;
   assign sweep_step = (state_ff == ST_UPDATE) && (policy_ff == POLICY_CLOCK)
                       && !found_ff && full && ref_vec[ptr_ff];
   assign commit     = (state_ff == ST_UPDATE) && !sweep_step && out_free;
   assign req_ready  = (state_ff == ST_IDLE) || commit;
   assign accept     = req_valid && req_ready;
   assign new_ref    = (policy_ff == POLICY_LRU) && found_ff && ref_vec[pos_ff];
   assign ptr_next   = ({1'b0, ptr_ff} + 1'b1 == capacity_ff) ? '0 : ptr_ff + 1'b1;

   // cell row
   for (genvar g = 0; g < MAX_ENTRIES; g++) begin : g_cell
      key_type nk;
      logic    nr;
      if (g == MAX_ENTRIES - 1) begin : g_end
         assign nk = key_vec[g];
         assign nr = ref_vec[g];
      end else begin : g_mid
         assign nk = key_vec[g+1];
         assign nr = ref_vec[g+1];
      end
      crp_cell u_cell (
         .clock    (clock),
         .reset    (reset),
         .op       (op_vec[g]),
         .nbr_key  (nk),
         .nbr_ref  (nr),
         .new_key  (key_ff),
         .new_ref  (new_ref),
         .look_key (key_ff),
         .key      (key_vec[g]),
         .ref_bit  (ref_vec[g]),
         .match    (match_vec[g])
      );
   end

   always_comb begin
      fill_type idx;
      for (int i = 0; i < MAX_ENTRIES; i++) begin
         idx = FILL_BITS'(i);
         op_vec[i].shift = commit && active && (
              ((policy_ff == POLICY_LRU) && found_ff && idx >= {1'b0, pos_ff}
               && idx < last)
           || (!found_ff && full && (policy_ff != POLICY_CLOCK) && idx < last));
         op_vec[i].load = commit && active && (
              ((policy_ff == POLICY_LRU) && found_ff && idx == last)
           || (!found_ff && !full && idx == fill_ff)
           || (!found_ff && full && (policy_ff != POLICY_CLOCK) && idx == last)
           || (!found_ff && full && (policy_ff == POLICY_CLOCK)
               && idx == {1'b0, ptr_ff}));
         op_vec[i].set_ref = commit && (policy_ff == POLICY_CLOCK) && found_ff
                             && idx == {1'b0, pos_ff};
         op_vec[i].clr_ref = sweep_step && idx == {1'b0, ptr_ff};
      end
   end

   always_comb begin
      found_in = 1'b0;
      pos_in   = '0;
      for (int i = MAX_ENTRIES - 1; i >= 0; i--) begin
         if (match_vec[i] && FILL_BITS'(i) < fill_ff) begin
            found_in = 1'b1;
            pos_in   = SLOT_BITS'(i);
         end
      end
   end

   always_comb begin
      if (csr_wdata == '0) begin
         cap_clamped = FILL_BITS'(1);
      end else if ({1'b0, csr_wdata} > (CSR_DATA_BITS+1)'(MAX_ENTRIES)) begin
         cap_clamped = FILL_BITS'(MAX_ENTRIES);
      end else begin
         cap_clamped = FILL_BITS'(csr_wdata);
      end
   end

   // seen map
   always_comb begin
      seen_we = 1'b0;
      seen_wa = key_ff;
      seen_wd = 1'b1;
      if (state_ff == ST_CLEAR) begin
         seen_we = 1'b1;
         seen_wa = clr_ff;
         seen_wd = 1'b0;
      end else if (commit && active && !found_ff && !seen_ff) begin
         seen_we = 1'b1;
      end
   end

   crp_ram #(.WIDTH(1), .DEPTH(KEY_SPACE)) u_seen (
      .clock   (clock),
      .wr_en   (seen_we),
      .wr_addr (seen_wa),
      .wr_data (seen_wd),
      .rd_addr (req_key),
      .rd_data (seen_rd)
   );

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_CLEAR:  if (clr_ff == '1) state_in = ST_IDLE;
         ST_IDLE:   if (accept) state_in = ST_LOOK;
         ST_LOOK:   state_in = ST_UPDATE;
         ST_UPDATE: if (commit) state_in = accept ? ST_LOOK : ST_IDLE;
         default:   state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_CLEAR;
         clr_ff   <= '0;
      end else begin
         state_ff <= state_in;
         if (state_ff == ST_CLEAR) clr_ff <= clr_ff + 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         key_ff <= req_key;
         byp_ff <= seen_we && (seen_wa == req_key);
      end
      if (state_ff == ST_LOOK) begin
         found_ff <= found_in;
         pos_ff   <= pos_in;
         seen_ff  <= seen_rd || byp_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         policy_ff    <= POLICY_FIFO;
         capacity_ff  <= FILL_BITS'(MAX_ENTRIES);
         fill_ff      <= '0;
         ptr_ff       <= '0;
         hit_cnt_ff   <= '0;
         miss_cnt_ff  <= '0;
         comp_cnt_ff  <= '0;
         capm_cnt_ff  <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (csr_wr_en) begin
            unique case (csr_index)
               CSR_POLICY: policy_ff <= csr_wdata[1:0];
               CSR_CAPACITY: begin
                  capacity_ff <= cap_clamped;
                  if (fill_ff > cap_clamped) fill_ff <= cap_clamped;
                  if ({1'b0, ptr_ff} >= cap_clamped) ptr_ff <= '0;
               end
               default: ;
            endcase
         end
         if (sweep_step) ptr_ff <= ptr_next;
         rsp_valid_ff <= commit || (rsp_valid_ff && !rsp_ready);
         if (commit) begin
            rsp_hit_ff   <= active && found_ff;
            rsp_kind_ff  <= !active || found_ff ? KIND_HIT
                          : (seen_ff ? KIND_CAPACITY : KIND_COMPULSORY);
            if (active) begin
               if (found_ff) begin
                  if (hit_cnt_ff != CNT_MAX) hit_cnt_ff <= hit_cnt_ff + 1'b1;
               end else begin
                  if (miss_cnt_ff != CNT_MAX) miss_cnt_ff <= miss_cnt_ff + 1'b1;
                  if (seen_ff) begin
                     if (capm_cnt_ff != CNT_MAX) capm_cnt_ff <= capm_cnt_ff + 1'b1;
                  end else begin
                     if (comp_cnt_ff != CNT_MAX) comp_cnt_ff <= comp_cnt_ff + 1'b1;
                  end
                  if (!full) begin
                     fill_ff <= fill_ff + 1'b1;
                  end else if (policy_ff == POLICY_CLOCK) begin
                     ptr_ff <= ptr_next;
                  end
               end
            end
         end
      end
   end

   assign rsp_valid            = rsp_valid_ff;
   assign rsp_hit              = rsp_hit_ff;
   assign rsp_miss_kind        = rsp_kind_ff;
   assign rsp_hits_total       = hit_cnt_ff;
   assign rsp_misses_total     = miss_cnt_ff;
   assign rsp_compulsory_total = comp_cnt_ff;
   assign rsp_capacity_total   = capm_cnt_ff;

endmodule

[rtl/crp_ram.sv]
`timescale 1ns / 1ps
module crp_ram #(
   parameter int WIDTH = 1,
   parameter int DEPTH = 1024
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

[rtl/crp_cell.sv]
`timescale 1ns / 1ps
module crp_cell (
   input  logic                 clock,
   input  logic                 reset,
   input  crp_pkg::cell_op_type op,
   input  crp_pkg::key_type     nbr_key,
   input  logic                 nbr_ref,
   input  crp_pkg::key_type     new_key,
   input  logic                 new_ref,
   input  crp_pkg::key_type     look_key,
   output crp_pkg::key_type     key,
   output logic                 ref_bit,
   output logic                 match
);
   import crp_pkg::*;

   key_type key_ff;
   logic    ref_ff;

   always_ff @(posedge clock) begin
      if (op.load) begin
         key_ff <= new_key;
      end else if (op.shift) begin
         key_ff <= nbr_key;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ref_ff <= 1'b0;
      end else begin
         priority if (op.load) begin
            ref_ff <= new_ref;
         end else if (op.shift) begin
            ref_ff <= nbr_ref;
         end else if (op.set_ref) begin
            ref_ff <= 1'b1;
         end else if (op.clr_ref) begin
            ref_ff <= 1'b0;
         end
      end
   end

   assign key     = key_ff;
   assign ref_bit = ref_ff;
   assign match   = (key_ff == look_key);

endmodule

[rtl/crp_checker.sv]
`timescale 1ns / 1ps
module crp_checker (
   input logic                      clock,
   input logic                      reset,
   input logic                      req_valid,
   input logic                      req_ready,
   input crp_pkg::key_type          req_key,
   input logic                      rsp_valid,
   input logic                      rsp_ready,
   input logic                      rsp_hit,
   input crp_pkg::kind_type         rsp_miss_kind,
   input crp_pkg::cnt_type          rsp_hits_total,
   input crp_pkg::cnt_type          rsp_misses_total,
   input crp_pkg::cnt_type          rsp_compulsory_total,
   input crp_pkg::cnt_type          rsp_capacity_total,
   input logic                      csr_wr_en,
   input logic                      csr_index,
   input logic [crp_pkg::CSR_DATA_BITS-1:0] csr_wdata
);
   import crp_pkg::*;

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid)
      else $error("rsp dropped while stalled");

   a_hit_kind: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_hit |-> rsp_miss_kind == KIND_HIT)
      else $error("hit with miss class");

   a_kind_code: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_miss_kind <= KIND_CAPACITY)
      else $error("bad miss class");

   a_hits_mono: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_ready ##1 rsp_valid |->
         rsp_hits_total >= $past(rsp_hits_total)
         && rsp_misses_total >= $past(rsp_misses_total))
      else $error("counter went backward");

endmodule

bind cache_replacement_policy crp_checker u_crp_checker (.*);

[bench/tb_cache_replacement_policy.sv]
`timescale 1ns / 1ps
module tb_cache_replacement_policy;
   import crp_pkg::*;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_ready;
   key_type req_key = '0;
   logic rsp_valid;
   logic rsp_ready = 1'b0;
   logic rsp_hit;
   kind_type rsp_miss_kind;
   cnt_type rsp_hits_total, rsp_misses_total, rsp_compulsory_total, rsp_capacity_total;
   logic csr_wr_en = 1'b0;
   logic csr_index = 1'b0;
   logic [CSR_DATA_BITS-1:0] csr_wdata = '0;

   cache_replacement_policy uut (.*);

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   typedef struct packed {
      logic     hit;
      kind_type kind;
      cnt_type  hits;
      cnt_type  misses;
      cnt_type  comp;
      cnt_type  capm;
   } access_result_type;

   // shadow cache
   policy_type m_policy;
   int unsigned m_cap;
   key_type m_keys[MAX_ENTRIES];
   logic m_valid[MAX_ENTRIES];
   logic m_ref[MAX_ENTRIES];
   int unsigned m_fill;
   int unsigned m_ptr;
   logic m_seen[KEY_SPACE];
   cnt_type m_hits, m_misses, m_comp, m_capm;

   access_result_type pending_results[$];
   int errors = 0;
   int checked = 0;
   int n_items = 0;
   int n_hits = 0;

   function automatic cnt_type sat_inc(cnt_type c);
      return (c == '1) ? c : c + 1'b1;
   endfunction

   function automatic void cache_reset();
      m_policy = POLICY_FIFO;
      m_cap = MAX_ENTRIES;
      for (int i = 0; i < MAX_ENTRIES; i++) begin
         m_keys[i] = '0; m_valid[i] = 1'b0; m_ref[i] = 1'b0;
      end
      for (int i = 0; i < KEY_SPACE; i++) m_seen[i] = 1'b0;
      m_fill = 0; m_ptr = 0;
      m_hits = '0; m_misses = '0; m_comp = '0; m_capm = '0;
   endfunction

   function automatic void drop_slot(int unsigned from);
      if (m_fill == 0 || from >= m_fill) return;
      for (int unsigned i = from; i + 1 < m_fill; i++) begin
         m_keys[i] = m_keys[i+1]; m_ref[i] = m_ref[i+1];
      end
      m_fill--;
      m_valid[m_fill] = 1'b0; m_ref[m_fill] = 1'b0;
   endfunction

   function automatic void push_key(key_type k);
      if (m_fill >= MAX_ENTRIES) return;
      m_keys[m_fill] = k; m_valid[m_fill] = 1'b1; m_ref[m_fill] = 1'b0;
      m_fill++;
   endfunction

   function automatic void cache_write(logic idx, logic [CSR_DATA_BITS-1:0] v);
      if (idx == CSR_POLICY) begin
         m_policy = policy_type'(v[1:0]);
      end else begin
         m_cap = (v == 0) ? 1 : (v > MAX_ENTRIES) ? MAX_ENTRIES : v;
         if (m_fill > m_cap) begin
            for (int unsigned i = m_cap; i < MAX_ENTRIES; i++) begin
               m_valid[i] = 1'b0; m_ref[i] = 1'b0;
            end
            m_fill = m_cap;
         end
         if (m_ptr >= m_cap) m_ptr = 0;
      end
   endfunction

   function automatic access_result_type cache_access(key_type k);
      access_result_type r;
      int unsigned pos = 0, p;
      logic found = 1'b0, rb;
      kind_type kind = KIND_HIT;
      if (m_policy != POLICY_IGNORE) begin
         for (int unsigned i = 0; i < m_fill; i++)
            if (!found && m_valid[i] && m_keys[i] == k) begin
               found = 1'b1; pos = i;
            end
         if (found) begin
            m_hits = sat_inc(m_hits);
            if (m_policy == POLICY_LRU) begin
               rb = m_ref[pos];
               drop_slot(pos);
               push_key(k);
               m_ref[m_fill-1] = rb;
            end else if (m_policy == POLICY_CLOCK) begin
               m_ref[pos] = 1'b1;
            end
         end else begin
            m_misses = sat_inc(m_misses);
            if (m_seen[k]) begin
               kind = KIND_CAPACITY; m_capm = sat_inc(m_capm);
            end else begin
               kind = KIND_COMPULSORY; m_comp = sat_inc(m_comp); m_seen[k] = 1'b1;
            end
            if (m_fill < m_cap) begin
               push_key(k);
            end else if (m_policy == POLICY_CLOCK) begin
               p = (m_ptr < m_cap) ? m_ptr : 0;
               while (m_ref[p]) begin
                  m_ref[p] = 1'b0; p = (p + 1) % m_cap;
               end
               m_keys[p] = k; m_valid[p] = 1'b1; m_ref[p] = 1'b0;
               m_ptr = (p + 1) % m_cap;
            end else begin
               drop_slot(0);
               push_key(k);
            end
         end
      end
      r.hit = found; r.kind = kind;
      r.hits = m_hits; r.misses = m_misses; r.comp = m_comp; r.capm = m_capm;
      return r;
   endfunction

   task automatic report_mismatch(string what, longint got, longint want);
      errors++;
      $display("mismatch at result %0d: %s got %0d want %0d", checked, what, got, want);
   endtask

   // result side
   initial begin : rsp_side
      access_result_type w;
      int gap;
      @(posedge clock);
      forever begin
         gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 11);
         if (gap > 0) begin
            rsp_ready <= 1'b0;
            repeat (gap) @(posedge clock);
         end
         rsp_ready <= 1'b1;
         @(posedge clock);
         while (!rsp_valid) @(posedge clock);
         if (pending_results.size() == 0) begin
            report_mismatch("unexpected result transfer", 1, 0);
         end else begin
            w = pending_results.pop_front();
            if (rsp_hit !== w.hit) report_mismatch("hit", rsp_hit, w.hit);
            if (rsp_miss_kind !== w.kind) report_mismatch("miss_kind", rsp_miss_kind, w.kind);
            if (rsp_hits_total !== w.hits) report_mismatch("hits", rsp_hits_total, w.hits);
            if (rsp_misses_total !== w.misses)
               report_mismatch("misses", rsp_misses_total, w.misses);
            if (rsp_compulsory_total !== w.comp)
               report_mismatch("compulsory", rsp_compulsory_total, w.comp);
            if (rsp_capacity_total !== w.capm)
               report_mismatch("capacity", rsp_capacity_total, w.capm);
            checked++;
         end
      end
   end

   // req_valid stays up after a transfer until the next call decides its gap
   task automatic send_key(key_type k, logic check_fixed, access_result_type fixed);
      access_result_type r;
      int gap;
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 11);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_key <= k;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      r = cache_access(k);
      if (r.hit) n_hits++;
      n_items++;
      pending_results.push_back(check_fixed ? fixed : r);
   endtask

   task automatic drain();
      req_valid <= 1'b0;
      while (pending_results.size() != 0) @(posedge clock);
      repeat (40) @(posedge clock);
   endtask

   task automatic csr_write(logic idx, logic [CSR_DATA_BITS-1:0] v);
      csr_wr_en <= 1'b1; csr_index <= idx; csr_wdata <= v;
      @(posedge clock);
      csr_wr_en <= 1'b0;
      cache_write(idx, v);
      @(posedge clock);
   endtask

   typedef struct {
      logic     is_csr;
      logic     idx;
      int       val;
      logic     fixed;
      logic     hit;
      kind_type kind;
      int       h, m, c, p;
   } dir_row_type;

   dir_row_type dir_table[] = '{
      '{0, 0, 0,    1, 0, KIND_COMPULSORY, 0, 1, 1, 0},
      '{0, 0, 0,    1, 1, KIND_HIT,        1, 1, 1, 0},
      '{0, 0, 1023, 1, 0, KIND_COMPULSORY, 1, 2, 2, 0},
      '{0, 0, 1023, 0, 0, KIND_HIT, 0, 0, 0, 0},
      '{1, CSR_CAPACITY, 0, 0, 0, KIND_HIT, 0, 0, 0, 0},
      '{0, 0, 5,    0, 0, KIND_HIT, 0, 0, 0, 0},
      '{0, 0, 0,    0, 0, KIND_HIT, 0, 0, 0, 0},
      '{1, CSR_CAPACITY, 31, 0, 0, KIND_HIT, 0, 0, 0, 0},
      '{1, CSR_POLICY, 3, 0, 0, KIND_HIT, 0, 0, 0, 0},
      '{0, 0, 682,  0, 0, KIND_HIT, 0, 0, 0, 0},
      '{1, CSR_POLICY, 1, 0, 0, KIND_HIT, 0, 0, 0, 0},
      '{1, CSR_CAPACITY, 2, 0, 0, KIND_HIT, 0, 0, 0, 0},
      '{0, 0, 341,  0, 0, KIND_HIT, 0, 0, 0, 0},
      '{0, 0, 0,    0, 0, KIND_HIT, 0, 0, 0, 0},
      '{0, 0, 341,  0, 0, KIND_HIT, 0, 0, 0, 0},
      '{0, 0, 7,    0, 0, KIND_HIT, 0, 0, 0, 0},
      '{0, 0, 5,    0, 0, KIND_HIT, 0, 0, 0, 0},
      '{1, CSR_POLICY, 2, 0, 0, KIND_HIT, 0, 0, 0, 0},
      '{1, CSR_CAPACITY, 3, 0, 0, KIND_HIT, 0, 0, 0, 0},
      '{0, 0, 1,    0, 0, KIND_HIT, 0, 0, 0, 0},
      '{0, 0, 1,    0, 0, KIND_HIT, 0, 0, 0, 0},
      '{0, 0, 2,    0, 0, KIND_HIT, 0, 0, 0, 0},
      '{0, 0, 3,    0, 0, KIND_HIT, 0, 0, 0, 0},
      '{0, 0, 4,    0, 0, KIND_HIT, 0, 0, 0, 0},
      '{0, 0, 1,    0, 0, KIND_HIT, 0, 0, 0, 0}
   };

   initial begin : req_side
      access_result_type fx;
      int pool_size, nphase, kmode;
      key_type k;
      key_type pool[$];
      cache_reset();
      repeat (3) @(posedge clock);
      reset <= 1'b0;
      foreach (dir_table[i]) begin
         if (dir_table[i].is_csr) begin
            drain();
            csr_write(dir_table[i].idx, CSR_DATA_BITS'(dir_table[i].val));
         end else begin
            fx.hit = dir_table[i].hit; fx.kind = dir_table[i].kind;
            fx.hits = cnt_type'(dir_table[i].h); fx.misses = cnt_type'(dir_table[i].m);
            fx.comp = cnt_type'(dir_table[i].c); fx.capm = cnt_type'(dir_table[i].p);
            send_key(KEY_BITS'(dir_table[i].val), dir_table[i].fixed, fx);
         end
      end
      // random phases: settings change, keys from a working set near capacity
      for (nphase = 0; nphase < 39; nphase++) begin
         drain();
         csr_write(CSR_POLICY, (nphase % 13 == 12) ? CSR_DATA_BITS'(POLICY_IGNORE)
                                                   : CSR_DATA_BITS'(nphase % 3));
         case (nphase % 5)
            0: csr_write(CSR_CAPACITY, CSR_DATA_BITS'(1));
            1: csr_write(CSR_CAPACITY, CSR_DATA_BITS'(16));
            2: csr_write(CSR_CAPACITY, CSR_DATA_BITS'($urandom_range(0, 31)));
            default: csr_write(CSR_CAPACITY, CSR_DATA_BITS'($urandom_range(2, 15)));
         endcase
         pool_size = m_cap + $urandom_range(0, 6);
         pool.delete();
         for (int j = 0; j < pool_size; j++)
            pool.push_back(KEY_BITS'($urandom_range(0, 1023)));
         repeat (50) begin
            kmode = $urandom_range(0, 9);
            if (kmode == 0) k = KEY_BITS'($urandom_range(0, 1023));
            else if (kmode == 1) k = $urandom_range(0, 1) ? 10'h3FF : 10'h000;
            else k = pool[$urandom_range(0, pool_size - 1)];
            send_key(k, 1'b0, fx);
         end
      end
      drain();
      $display("ran %0d accesses, %0d hits, %0d results checked over FIFO/LRU/CLOCK",
               n_items, n_hits, checked);
      if (errors == 0)
         $display("tb_cache_replacement_policy: done, clean");
      else
         $display("tb_cache_replacement_policy: done, errors");
      $finish;
   end

   initial begin : watchdog
      #2000000;
      $display("tb_cache_replacement_policy: done, errors");
      $finish;
   end

endmodule

[files.f]
rtl/crp_pkg.sv
rtl/crp_ram.sv
rtl/crp_cell.sv
rtl/cache_replacement_policy.sv
rtl/crp_checker.sv
bench/tb_cache_replacement_policy.sv
